/* hw/rtl/chacha_pkg.sv */
// Shared types and constants for the ChaCha byte-stream cipher.
// Used by the interfaces' users, the controller, the datapath and the top level.
`default_nettype none

package chacha_pkg;

    typedef logic [31:0] t_word;

    // Input item kinds; the fourth code behaves as a skip
    typedef enum logic [1:0] {
        KIND_XOR       = 2'd0,
        KIND_KEYSTREAM = 2'd1,
        KIND_SKIP      = 2'd2
    } t_kind;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_W0      = 3'd0;
    localparam logic [2:0] CFG_KEY_W1      = 3'd1;
    localparam logic [2:0] CFG_KEY_W2      = 3'd2;
    localparam logic [2:0] CFG_KEY_W3      = 3'd3;
    localparam logic [2:0] CFG_NONCE_LO    = 3'd4;
    localparam logic [2:0] CFG_NONCE_HI    = 3'd5;
    localparam logic [2:0] CFG_ROUND_COUNT = 3'd6;
    localparam logic [2:0] CFG_MODE        = 3'd7;

    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 64;

    // Legal round counts and reset values
    localparam logic [4:0] ROUNDS_8     = 5'd8;
    localparam logic [4:0] ROUNDS_12    = 5'd12;
    localparam logic [4:0] ROUNDS_20    = 5'd20;
    localparam logic [1:0] MODE_RESET   = 2'd1;

    // "expand 32-byte k" / "expand 16-byte k"
    localparam t_word SIGMA_0     = 32'h6170_7865;
    localparam t_word SIGMA_1_128 = 32'h3120_646E;
    localparam t_word SIGMA_2_128 = 32'h7962_2D36;
    localparam t_word SIGMA_1_256 = 32'h3320_646E;
    localparam t_word SIGMA_2_256 = 32'h7962_2D32;
    localparam t_word SIGMA_3     = 32'h6B20_6574;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;    // latch the incoming item
        logic       direct;  // keystream already present: form the result now
        logic       load;    // load the initial block state
        logic       round;   // one half quarter-round on all four lanes
        logic [1:0] phase;   // bit1: diagonal, bit0: second half
        logic       feed;    // feed-forward, bump the block counter
        logic       emit;    // form the result from the fresh block
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       need_block;  // byte position at start or end of a block
        logic       in_emits;    // incoming kind produces a result
        logic       held_emits;  // latched kind produces a result
        logic [4:0] round_count;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/chacha_in_if.sv */
// Input channel of the ChaCha cipher: valid/ready with kind and data byte.
// Stand-alone; no package dependency.
`default_nettype none

interface chacha_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/chacha_out_if.sv */
// Output channel of the ChaCha cipher: valid/ready with one result byte.
// Stand-alone; no package dependency.
`default_nettype none

interface chacha_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/chacha_ctrl.sv */
// Controller for the ChaCha cipher: sequences block generation and owns
// the handshakes. Depends on chacha_pkg.
`default_nettype none

module chacha_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    input  chacha_pkg::t_dp_status i_status,
    output chacha_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FEED,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [5:0] r_step;
    logic       r_out_valid;
    logic [5:0] last_step;
    logic       in_fire;

    // Two half steps per round
    assign last_step = {i_status.round_count, 1'b0} - 6'd1;
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Decode datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.take   = in_fire;
        o_cmd.direct = in_fire && !i_status.need_block;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.round  = (r_state == S_ROUND);
        o_cmd.phase  = r_step[1:0];
        o_cmd.feed   = (r_state == S_FEED);
        o_cmd.emit   = (r_state == S_EMIT);
    end

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a fresh result, or drop the one just transferred
            if (o_cmd.direct) begin
                r_out_valid <= i_status.in_emits;
            end else if (o_cmd.emit) begin
                r_out_valid <= i_status.held_emits;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_status.need_block) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_step == last_step) begin
                        r_state <= S_FEED;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                S_FEED: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/chacha_dp.sv */
// Datapath for the ChaCha cipher: configuration registers, block counter,
// byte position, the 16-word block state with four quarter-round lanes.
// Depends on chacha_pkg.
`default_nettype none

module chacha_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [chacha_pkg::CfgIndexW-1:0]    i_cfg_index,
    input  logic [chacha_pkg::CfgDataW-1:0]     i_cfg_data,
    input  chacha_pkg::t_dp_cmd                 i_cmd,
    output chacha_pkg::t_dp_status              o_status,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_data_in,
    output logic [7:0]                          o_data_out
);

    typedef struct packed {
        chacha_pkg::t_word a;
        chacha_pkg::t_word b;
        chacha_pkg::t_word c;
        chacha_pkg::t_word d;
    } t_quad;

    // Half of a quarter round: two add/xor/rotate lines
    function automatic t_quad qr_half(t_quad q, logic second);
        t_quad             r;
        chacha_pkg::t_word t;
        r   = q;
        r.a = q.a + q.b;
        t   = q.d ^ r.a;
        r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
        r.c = q.c + r.d;
        t   = q.b ^ r.c;
        r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
        return r;
    endfunction

    function automatic logic kind_emits(logic [1:0] kind);
        return (kind == chacha_pkg::KIND_XOR) || (kind == chacha_pkg::KIND_KEYSTREAM);
    endfunction

    // Configuration and control state
    logic [63:0] r_key_w0, r_key_w1, r_key_w2, r_key_w3, r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [4:0]  r_round_count;
    logic [1:0]  r_mode;
    logic [63:0] r_counter;
    logic [6:0]  r_pos;

    // Payload
    chacha_pkg::t_word r_x [16];
    chacha_pkg::t_word n_x [16];
    chacha_pkg::t_word init_w [16];
    chacha_pkg::t_word n_round [16];
    chacha_pkg::t_word r_w13;
    logic [1:0]        r_kind;
    logic [7:0]        r_data;
    logic [7:0]        r_out_data;

    logic [4:0]        cfg_rounds;
    logic              wide_key;
    logic              long_nonce;
    chacha_pkg::t_word ks_word;
    logic [7:0]        ks_byte;
    logic [1:0]        sel_kind;
    logic [7:0]        sel_data;

    assign wide_key   = r_mode[0];
    assign long_nonce = r_mode[1];
    assign cfg_rounds = i_cfg_data[4:0];

    // Build the initial block state
    always_comb begin
        init_w[0] = chacha_pkg::SIGMA_0;
        init_w[1] = wide_key ? chacha_pkg::SIGMA_1_256 : chacha_pkg::SIGMA_1_128;
        init_w[2] = wide_key ? chacha_pkg::SIGMA_2_256 : chacha_pkg::SIGMA_2_128;
        init_w[3] = chacha_pkg::SIGMA_3;
        init_w[4] = r_key_w0[31:0];
        init_w[5] = r_key_w0[63:32];
        init_w[6] = r_key_w1[31:0];
        init_w[7] = r_key_w1[63:32];
        init_w[8]  = wide_key ? r_key_w2[31:0]  : r_key_w0[31:0];
        init_w[9]  = wide_key ? r_key_w2[63:32] : r_key_w0[63:32];
        init_w[10] = wide_key ? r_key_w3[31:0]  : r_key_w1[31:0];
        init_w[11] = wide_key ? r_key_w3[63:32] : r_key_w1[63:32];
        init_w[12] = r_counter[31:0];
        if (long_nonce) begin
            // counter carry spills into the first nonce word
            init_w[13] = r_nonce_lo[31:0] + r_counter[63:32];
            init_w[14] = r_nonce_lo[63:32];
            init_w[15] = r_nonce_hi;
        end else begin
            init_w[13] = r_counter[63:32];
            init_w[14] = r_nonce_lo[31:0];
            init_w[15] = r_nonce_lo[63:32];
        end
    end

    // Four lanes of half quarter-rounds, column or diagonal
    always_comb begin
        t_quad      q;
        logic [3:0] ib, ic, id;
        logic [1:0] sh;
        n_round = r_x;
        for (int l = 0; l < 4; l++) begin
            sh = i_cmd.phase[1] ? 2'd1 : 2'd0;
            ib = {2'b01, 2'(l) + sh};
            ic = {2'b10, 2'(l) + {sh[0], 1'b0}};
            id = {2'b11, 2'(l) + sh + {sh[0], 1'b0}};
            q.a = r_x[l];
            q.b = r_x[ib];
            q.c = r_x[ic];
            q.d = r_x[id];
            q = qr_half(q, i_cmd.phase[0]);
            n_round[l]  = q.a;
            n_round[ib] = q.b;
            n_round[ic] = q.c;
            n_round[id] = q.d;
        end
    end

    // Next block state: load, round or feed-forward
    always_comb begin
        n_x = r_x;
        priority if (i_cmd.load) begin
            n_x = init_w;
        end else if (i_cmd.round) begin
            n_x = n_round;
        end else if (i_cmd.feed) begin
            for (int i = 0; i < 16; i++) begin
                n_x[i] = r_x[i] + ((i == 13) ? r_w13 : init_w[i]);
            end
        end
    end

    // Select the keystream byte and form the result
    assign ks_word  = r_x[r_pos[5:2]];
    assign ks_byte  = ks_word[{r_pos[1:0], 3'b000} +: 8];
    assign sel_kind = i_cmd.take ? i_kind : r_kind;
    assign sel_data = i_cmd.take ? i_data_in : r_data;

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (i_cmd.load) begin
            r_w13 <= init_w[13];
        end
        if (i_cmd.take) begin
            r_kind <= i_kind;
            r_data <= i_data_in;
        end
        if (i_cmd.direct || i_cmd.emit) begin
            r_out_data <= (sel_kind == chacha_pkg::KIND_XOR) ? (sel_data ^ ks_byte) : ks_byte;
        end
    end

    // Configuration writes, block counter and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_w0      <= '0;
            r_key_w1      <= '0;
            r_key_w2      <= '0;
            r_key_w3      <= '0;
            r_nonce_lo    <= '0;
            r_nonce_hi    <= '0;
            r_round_count <= chacha_pkg::ROUNDS_20;
            r_mode        <= chacha_pkg::MODE_RESET;
            r_counter     <= '0;
            r_pos         <= '0;
        end else begin
            if (i_cmd.direct || i_cmd.emit) begin
                r_pos <= r_pos + 7'd1;
            end
            if (i_cmd.feed) begin
                r_counter <= r_counter + 64'd1;
                r_pos     <= '0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    chacha_pkg::CFG_KEY_W0: r_key_w0 <= i_cfg_data;
                    chacha_pkg::CFG_KEY_W1: r_key_w1 <= i_cfg_data;
                    chacha_pkg::CFG_KEY_W2: r_key_w2 <= i_cfg_data;
                    chacha_pkg::CFG_KEY_W3: r_key_w3 <= i_cfg_data;
                    chacha_pkg::CFG_NONCE_LO: begin
                        r_nonce_lo <= i_cfg_data;
                        r_counter  <= '0;
                    end
                    chacha_pkg::CFG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                    chacha_pkg::CFG_ROUND_COUNT: begin
                        // drop round counts other than 8, 12 and 20
                        if (cfg_rounds == chacha_pkg::ROUNDS_8 ||
                            cfg_rounds == chacha_pkg::ROUNDS_12 ||
                            cfg_rounds == chacha_pkg::ROUNDS_20) begin
                            r_round_count <= cfg_rounds;
                        end
                    end
                    chacha_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.need_block  = (r_pos == 7'd0) || r_pos[6];
        o_status.in_emits    = kind_emits(i_kind);
        o_status.held_emits  = kind_emits(r_kind);
        o_status.round_count = r_round_count;
    end

    assign o_data_out = r_out_data;

endmodule

`default_nettype wire

/* hw/rtl/chacha_stream_cipher.sv */
// ChaCha byte-stream cipher, top level. Depends on chacha_pkg, chacha_in_if,
// chacha_out_if, chacha_ctrl and chacha_dp.
// Usage:
//   i_data carries one byte per transfer with a kind: XOR the byte with
//   keystream, return raw keystream, or skip (consume keystream, no result).
//   o_data carries one result byte per XOR or keystream transfer.
//   Configuration (key, nonce, round count, mode) is written through
//   i_cfg_we/i_cfg_index/i_cfg_data while the block is idle; it is sampled
//   when a keystream block is generated. Writing nonce_lo clears the block
//   counter but keeps the byte position.
// Timing:
//   A byte within a current 64-byte block gives its result in the cycle after
//   the transfer, and a new byte is taken every cycle while o_data drains.
//   The first byte of each 64-byte block first generates the block: a load
//   step, the half-round steps of every round on the four-lane datapath, a
//   feed-forward step and an output step, and then gives its result.
// Reset clears the block counter and byte position and restores the register
//   defaults (20 rounds, 256-bit key, 8-byte nonce).
// When o_data stalls the result is held in the output register and i_data
//   takes the next byte only once that register is free.
`default_nettype none

module chacha_stream_cipher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [chacha_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [chacha_pkg::CfgDataW-1:0]  i_cfg_data,
    chacha_in_if.sink                        i_data,
    chacha_out_if.source                     o_data
);

    chacha_pkg::t_dp_cmd    cmd;
    chacha_pkg::t_dp_status status;
    logic                   in_ready;
    logic                   out_valid;
    logic [7:0]             out_data;

    chacha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_data.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_data.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    chacha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_kind      (i_data.kind),
        .i_data_in   (i_data.data_in),
        .o_data_out  (out_data)
    );

    // Drive channel handshakes and payload
    assign i_data.ready    = in_ready;
    assign o_data.valid    = out_valid;
    assign o_data.data_out = out_data;

endmodule

`default_nettype wire
